### rtl/trsam_pkg.sv
// ----------------------------------------------------------------------------
// trsam_pkg: shared types and constants for the TRS to affine matrix unit
// Field widths, fixed-point formats and the records that travel between the
// pipeline stages.
// ----------------------------------------------------------------------------
package trsam_pkg;

	// Field widths of one input and one result word.
	localparam int QW   = 16;  // quaternion component, Q2.14
	localparam int SW   = 16;  // scale component, Q8.8
	localparam int PW   = 32;  // position component, Q16.16
	localparam int OW   = 32;  // matrix entry, Q16.16

	// Internal widths.
	localparam int PRODW = 2 * QW;        // quaternion component product, Q4.28
	localparam int ROTW  = PRODW + 2;     // rotation entry, Q.28, range +-2^32
	localparam int MULW  = ROTW + SW;     // scaled rotation entry, Q.36
	localparam int RNDW  = MULW + 1;      // scaled entry plus rounding offset

	// Rounding from Q.36 down to Q16.16.
	localparam int FRAC_SHIFT = 20;
	localparam int SHW        = RNDW - FRAC_SHIFT;  // significant bits after shift

	// Packed bus widths.
	localparam int IN_DW  = 3 * PW + 4 * QW + 3 * SW;  // 208 bits, 26 bytes
	localparam int OUT_DW = 12 * OW;                   // 384 bits, 48 bytes

	// One in Q.28 at rotation entry width.
	localparam logic signed [ROTW-1:0] ONE_Q28 = ROTW'(64'sd1 <<< 28);

	typedef logic signed [QW-1:0]    quat_e_t;
	typedef logic signed [SW-1:0]    scl_e_t;
	typedef logic signed [PW-1:0]    pos_e_t;
	typedef logic signed [OW-1:0]    out_e_t;
	typedef logic signed [PRODW-1:0] prod_e_t;
	typedef logic signed [ROTW-1:0]  rot_e_t;
	typedef logic signed [MULW-1:0]  mul_e_t;

	typedef struct packed {
		pos_e_t x;
		pos_e_t y;
		pos_e_t z;
	} pos_t;

	typedef struct packed {
		scl_e_t x;
		scl_e_t y;
		scl_e_t z;
	} scl_t;

	typedef struct packed {
		quat_e_t x;
		quat_e_t y;
		quat_e_t z;
		quat_e_t w;
	} quat_t;

	// The nine quaternion component products.
	typedef struct packed {
		prod_e_t xx;
		prod_e_t yy;
		prod_e_t zz;
		prod_e_t xy;
		prod_e_t xz;
		prod_e_t yz;
		prod_e_t wx;
		prod_e_t wy;
		prod_e_t wz;
	} qprod_t;

	// Unscaled rotation matrix, column c row r.
	typedef struct packed {
		rot_e_t c0_r0;
		rot_e_t c0_r1;
		rot_e_t c0_r2;
		rot_e_t c1_r0;
		rot_e_t c1_r1;
		rot_e_t c1_r2;
		rot_e_t c2_r0;
		rot_e_t c2_r1;
		rot_e_t c2_r2;
	} rotm_t;

	// Scaled rotation matrix before rounding.
	typedef struct packed {
		mul_e_t c0_r0;
		mul_e_t c0_r1;
		mul_e_t c0_r2;
		mul_e_t c1_r0;
		mul_e_t c1_r1;
		mul_e_t c1_r2;
		mul_e_t c2_r0;
		mul_e_t c2_r1;
		mul_e_t c2_r2;
	} mulm_t;

	// Final linear part in Q16.16.
	typedef struct packed {
		out_e_t c0_r0;
		out_e_t c0_r1;
		out_e_t c0_r2;
		out_e_t c1_r0;
		out_e_t c1_r1;
		out_e_t c1_r2;
		out_e_t c2_r0;
		out_e_t c2_r1;
		out_e_t c2_r2;
	} outm_t;

endpackage

### rtl/trsam_qprod.sv
// ----------------------------------------------------------------------------
// trsam_qprod: quaternion product stage
// First pipeline stage. Forms the nine 16x16 component products of the
// quaternion and carries scale and position along.
// ----------------------------------------------------------------------------
module trsam_qprod (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  trsam_pkg::quat_t   quat,
	input  trsam_pkg::scl_t    scale,
	input  trsam_pkg::pos_t    pos,
	output logic               out_valid,
	input  logic               out_ready,
	output trsam_pkg::qprod_t  prod_s1,
	output trsam_pkg::scl_t    scale_s1,
	output trsam_pkg::pos_t    pos_s1
);

	logic valid_s1;

	// The stage takes a word when it is empty or its word moves on.
	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Component products, exact in Q4.28.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1.xx <= quat.x * quat.x;
			prod_s1.yy <= quat.y * quat.y;
			prod_s1.zz <= quat.z * quat.z;
			prod_s1.xy <= quat.x * quat.y;
			prod_s1.xz <= quat.x * quat.z;
			prod_s1.yz <= quat.y * quat.z;
			prod_s1.wx <= quat.w * quat.x;
			prod_s1.wy <= quat.w * quat.y;
			prod_s1.wz <= quat.w * quat.z;
			scale_s1   <= scale;
			pos_s1     <= pos;
		end
	end

endmodule

### rtl/trsam_rot.sv
// ----------------------------------------------------------------------------
// trsam_rot: rotation matrix stage
// Second pipeline stage. Combines the component products into the nine
// unnormalized rotation entries in Q.28.
// ----------------------------------------------------------------------------
module trsam_rot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  trsam_pkg::qprod_t  prod,
	input  trsam_pkg::scl_t    scale,
	input  trsam_pkg::pos_t    pos,
	output logic               out_valid,
	input  logic               out_ready,
	output trsam_pkg::rotm_t   rot_s2,
	output trsam_pkg::scl_t    scale_s2,
	output trsam_pkg::pos_t    pos_s2
);

	logic valid_s2;

	// Twice the sum of two products, exact at rotation entry width.
	function automatic trsam_pkg::rot_e_t twice_sum(input trsam_pkg::prod_e_t a,
			input trsam_pkg::prod_e_t b);
		logic signed [trsam_pkg::PRODW:0] s;
		s = {a[trsam_pkg::PRODW-1], a} + {b[trsam_pkg::PRODW-1], b};
		return $signed({s, 1'b0});
	endfunction

	// Twice the difference of two products.
	function automatic trsam_pkg::rot_e_t twice_diff(input trsam_pkg::prod_e_t a,
			input trsam_pkg::prod_e_t b);
		logic signed [trsam_pkg::PRODW:0] s;
		s = {a[trsam_pkg::PRODW-1], a} - {b[trsam_pkg::PRODW-1], b};
		return $signed({s, 1'b0});
	endfunction

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Diagonal entries are one minus twice a sum; the others are twice a sum or difference.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rot_s2.c0_r0 <= trsam_pkg::ONE_Q28 - twice_sum(prod.yy, prod.zz);
			rot_s2.c0_r1 <= twice_sum(prod.xy, prod.wz);
			rot_s2.c0_r2 <= twice_diff(prod.xz, prod.wy);
			rot_s2.c1_r0 <= twice_diff(prod.xy, prod.wz);
			rot_s2.c1_r1 <= trsam_pkg::ONE_Q28 - twice_sum(prod.xx, prod.zz);
			rot_s2.c1_r2 <= twice_sum(prod.yz, prod.wx);
			rot_s2.c2_r0 <= twice_sum(prod.xz, prod.wy);
			rot_s2.c2_r1 <= twice_diff(prod.yz, prod.wx);
			rot_s2.c2_r2 <= trsam_pkg::ONE_Q28 - twice_sum(prod.xx, prod.yy);
			scale_s2     <= scale;
			pos_s2       <= pos;
		end
	end

endmodule

### rtl/trsam_scl.sv
// ----------------------------------------------------------------------------
// trsam_scl: scale and round stages
// Third and fourth pipeline stages. Multiplies each rotation column by its
// scale component, then rounds to Q16.16 and saturates. The fourth stage
// register is the output register of the unit.
// ----------------------------------------------------------------------------
module trsam_scl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  trsam_pkg::rotm_t   rot,
	input  trsam_pkg::scl_t    scale,
	input  trsam_pkg::pos_t    pos,
	output logic               out_valid,
	input  logic               out_ready,
	output trsam_pkg::outm_t   mat_s4,
	output trsam_pkg::pos_t    pos_s4
);

	logic             valid_s3;
	logic             valid_s4;
	logic             ready_s4;
	trsam_pkg::mulm_t mul_s3;
	trsam_pkg::pos_t  pos_s3;

	// Round to nearest with ties up, drop 20 fraction bits, clamp to 32 bits.
	function automatic trsam_pkg::out_e_t round_sat(input trsam_pkg::mul_e_t v);
		logic signed [trsam_pkg::RNDW-1:0] r;
		logic signed [trsam_pkg::SHW-1:0]  q;
		logic signed [trsam_pkg::OW:0]     qe;
		r = {v[trsam_pkg::MULW-1], v} + (trsam_pkg::RNDW'(1) << (trsam_pkg::FRAC_SHIFT - 1));
		q = r[trsam_pkg::RNDW-1:trsam_pkg::FRAC_SHIFT];
		// Compare one bit wider than the output so both limits are representable.
		qe = {{(trsam_pkg::OW + 1 - trsam_pkg::SHW){q[trsam_pkg::SHW-1]}}, q};
		if (qe > (trsam_pkg::OW + 1)'(32'sh7fff_ffff)) begin
			return trsam_pkg::out_e_t'(32'sh7fff_ffff);
		end else if (qe < (trsam_pkg::OW + 1)'(32'sh8000_0000)) begin
			return trsam_pkg::out_e_t'(32'sh8000_0000);
		end else begin
			return trsam_pkg::out_e_t'(q);
		end
	endfunction

	assign ready_s4  = !valid_s4 || out_ready;
	assign in_ready  = !valid_s3 || ready_s4;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Column c of the rotation matrix times scale component c.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mul_s3.c0_r0 <= rot.c0_r0 * scale.x;
			mul_s3.c0_r1 <= rot.c0_r1 * scale.x;
			mul_s3.c0_r2 <= rot.c0_r2 * scale.x;
			mul_s3.c1_r0 <= rot.c1_r0 * scale.y;
			mul_s3.c1_r1 <= rot.c1_r1 * scale.y;
			mul_s3.c1_r2 <= rot.c1_r2 * scale.y;
			mul_s3.c2_r0 <= rot.c2_r0 * scale.z;
			mul_s3.c2_r1 <= rot.c2_r1 * scale.z;
			mul_s3.c2_r2 <= rot.c2_r2 * scale.z;
			pos_s3       <= pos;
		end
	end

	// Rounding and saturation into the output register.
	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			mat_s4.c0_r0 <= round_sat(mul_s3.c0_r0);
			mat_s4.c0_r1 <= round_sat(mul_s3.c0_r1);
			mat_s4.c0_r2 <= round_sat(mul_s3.c0_r2);
			mat_s4.c1_r0 <= round_sat(mul_s3.c1_r0);
			mat_s4.c1_r1 <= round_sat(mul_s3.c1_r1);
			mat_s4.c1_r2 <= round_sat(mul_s3.c1_r2);
			mat_s4.c2_r0 <= round_sat(mul_s3.c2_r0);
			mat_s4.c2_r1 <= round_sat(mul_s3.c2_r1);
			mat_s4.c2_r2 <= round_sat(mul_s3.c2_r2);
			pos_s4       <= pos_s3;
		end
	end

endmodule

### rtl/trs_to_affine_matrix_unit.sv
// ----------------------------------------------------------------------------
// trs_to_affine_matrix_unit: local transform to affine matrix
// Builds the upper three rows of the column-major matrix T*R*S from a
// position, an unnormalized quaternion and a per-axis scale.
//
//   Channel  Direction  Bits  Contents
//   s_axis   in         208   pos_x/y/z Q16.16, quat_x/y/z/w Q2.14, scale_x/y/z Q8.8
//   m_axis   out        384   c0_r0..c2_r2 Q16.16 saturated, trans_x/y/z Q16.16
//
// Four register stages: products, rotation entries, scaling, rounding.
// An accepted word passes the product, rotation, scaling and rounding registers
// in order; one word per cycle is sustained while m_axis is not stalled.
// During a stall on m_axis words still move up into empty stages;
// s_axis_tready drops only once every stage is full.
// arst_n clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module trs_to_affine_matrix_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
	input  logic [trsam_pkg::IN_DW-1:0]   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2,
	// trans_x, trans_y, trans_z
	output logic [trsam_pkg::OUT_DW-1:0]  m_axis_tdata
);

	trsam_pkg::quat_t  quat;
	trsam_pkg::scl_t   scale;
	trsam_pkg::pos_t   pos;
	trsam_pkg::qprod_t prod_s1;
	trsam_pkg::scl_t   scale_s1;
	trsam_pkg::pos_t   pos_s1;
	trsam_pkg::rotm_t  rot_s2;
	trsam_pkg::scl_t   scale_s2;
	trsam_pkg::pos_t   pos_s2;
	trsam_pkg::outm_t  mat_s4;
	trsam_pkg::pos_t   pos_s4;
	logic              valid_s1;
	logic              ready_s1;
	logic              valid_s2;
	logic              ready_s2;

	// Unpack the input word, first field in the lowest bits.
	assign pos.x   = s_axis_tdata[31:0];
	assign pos.y   = s_axis_tdata[63:32];
	assign pos.z   = s_axis_tdata[95:64];
	assign quat.x  = s_axis_tdata[111:96];
	assign quat.y  = s_axis_tdata[127:112];
	assign quat.z  = s_axis_tdata[143:128];
	assign quat.w  = s_axis_tdata[159:144];
	assign scale.x = s_axis_tdata[175:160];
	assign scale.y = s_axis_tdata[191:176];
	assign scale.z = s_axis_tdata[207:192];

	trsam_qprod u_qprod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.quat      (quat),
		.scale     (scale),
		.pos       (pos),
		.out_valid (valid_s1),
		.out_ready (ready_s1),
		.prod_s1   (prod_s1),
		.scale_s1  (scale_s1),
		.pos_s1    (pos_s1)
	);

	trsam_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s1),
		.prod      (prod_s1),
		.scale     (scale_s1),
		.pos       (pos_s1),
		.out_valid (valid_s2),
		.out_ready (ready_s2),
		.rot_s2    (rot_s2),
		.scale_s2  (scale_s2),
		.pos_s2    (pos_s2)
	);

	trsam_scl u_scl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (ready_s2),
		.rot       (rot_s2),
		.scale     (scale_s2),
		.pos       (pos_s2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.mat_s4    (mat_s4),
		.pos_s4    (pos_s4)
	);

	// Pack the result word, first field in the lowest bits.
	assign m_axis_tdata = {pos_s4.z, pos_s4.y, pos_s4.x,
		mat_s4.c2_r2, mat_s4.c2_r1, mat_s4.c2_r0,
		mat_s4.c1_r2, mat_s4.c1_r1, mat_s4.c1_r0,
		mat_s4.c0_r2, mat_s4.c0_r1, mat_s4.c0_r0};

endmodule

### rtl/trsam_chk.sv
// ----------------------------------------------------------------------------
// trsam_chk: port checker for the TRS to affine matrix unit
// Watches the stream ports for handshake rules, pipeline flow and the
// translation pass-through latency.
// ----------------------------------------------------------------------------
module trsam_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [trsam_pkg::IN_DW-1:0]   s_axis_tdata,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [trsam_pkg::OUT_DW-1:0]  m_axis_tdata
);

	// A stalled output word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word withdrawn while stalled");

	// A stalled output word keeps its data.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// With no word at the output the pipeline cannot be full.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output is empty");

	// With the output flowing, an accepted word passes the product, rotation, scaling and
	// rounding registers and appears with its position as the translation column.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
		##1 m_axis_tready |=> m_axis_tvalid
		&& (m_axis_tdata[383:288] == $past(s_axis_tdata[95:0], 4)))
		else $error("translation not delivered after four cycles");

endmodule

bind trs_to_affine_matrix_unit trsam_chk u_trsam_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression for the TRS to affine matrix unit
// Streams local transforms into s_axis and checks every matrix word on m_axis
// against a behavioral predictor. The predictor builds the rotation matrix from
// the quaternion products, scales, rounds and saturates each entry. A directed
// set covers identity, large entries, rounding ties and extreme inputs, and a
// random set follows. Both sides idle in random bursts, the receiver holds off
// once for a long stretch, and the sender pauses once for a full drain.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     RANDOM_XFORMS = 1325;
	localparam int     DRAIN_AT      = 700;   // random item that waits for a drain
	localparam int     HOLD_AT       = 400;   // accepted count that starts the long hold
	localparam int     HOLD_CYCLES   = 300;
	localparam int     QUIET_TAIL    = 120;   // last pending items sent with no idling
	localparam int     STUCK_LIMIT   = 2000;
	localparam int     FLUSH_CYCLES  = 20;
	localparam longint UNIT_Q28      = 64'sd1 <<< 28;
	localparam longint ROUND_HALF    = 64'sd1 <<< 19;
	localparam longint SAT_HI        = 64'sd2147483647;
	localparam longint SAT_LO        = -64'sd2147483648;

	typedef struct {
		trsam_pkg::pos_t  pos;
		trsam_pkg::quat_t quat;
		trsam_pkg::scl_t  scl;
		logic             drain_first;
	} xform_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	// pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
	logic [trsam_pkg::IN_DW-1:0]    s_axis_tdata = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2,
	// trans_x, trans_y, trans_z
	logic [trsam_pkg::OUT_DW-1:0]   m_axis_tdata;

	xform_t                         pending_xforms[$];
	logic [trsam_pkg::OUT_DW-1:0]   expected_mats[$];
	logic                           xform_taken = 1'b0;
	int                             accepted_xforms = 0;
	int                             mismatch_count = 0;
	int                             stuck_cycles = 0;
	int                             src_gap = 0;
	int                             snk_gap = 0;
	int                             hold_left = 0;
	logic                           hold_done = 1'b0;

	const string entry_names[12] = '{"c0_r0", "c0_r1", "c0_r2", "c1_r0", "c1_r1",
		"c1_r2", "c2_r0", "c2_r1", "c2_r2", "trans_x", "trans_y", "trans_z"};

	trs_to_affine_matrix_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Matrix word for one transform, packed in m_axis order.
	function automatic logic [trsam_pkg::OUT_DW-1:0] predict_matrix(xform_t xf);
		longint            qx, qy, qz, qw;
		longint            xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint            rot[9];
		longint            scl[3];
		longint            v;
		trsam_pkg::out_e_t lin[9];
		qx = xf.quat.x;
		qy = xf.quat.y;
		qz = xf.quat.z;
		qw = xf.quat.w;
		scl[0] = xf.scl.x;
		scl[1] = xf.scl.y;
		scl[2] = xf.scl.z;
		xx = qx * qx; yy = qy * qy; zz = qz * qz;
		xy = qx * qy; xz = qx * qz; yz = qy * qz;
		wx = qw * qx; wy = qw * qy; wz = qw * qz;
		// Rotation entries in Q.28, column by column.
		rot[0] = UNIT_Q28 - 2 * (yy + zz);
		rot[1] = 2 * (xy + wz);
		rot[2] = 2 * (xz - wy);
		rot[3] = 2 * (xy - wz);
		rot[4] = UNIT_Q28 - 2 * (xx + zz);
		rot[5] = 2 * (yz + wx);
		rot[6] = 2 * (xz + wy);
		rot[7] = 2 * (yz - wx);
		rot[8] = UNIT_Q28 - 2 * (xx + yy);
		// Scale by column, round half up from Q.36 to Q16.16, then clamp.
		for (int e = 0; e < 9; e++) begin
			v = (rot[e] * scl[e / 3] + ROUND_HALF) >>> 20;
			if (v > SAT_HI) begin
				v = SAT_HI;
			end
			if (v < SAT_LO) begin
				v = SAT_LO;
			end
			lin[e] = trsam_pkg::out_e_t'(v);
		end
		return {xf.pos.z, xf.pos.y, xf.pos.x, lin[8], lin[7], lin[6], lin[5], lin[4],
			lin[3], lin[2], lin[1], lin[0]};
	endfunction

	function automatic logic [15:0] corner16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_xform(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [15:0] qx, logic [15:0] qy, logic [15:0] qz, logic [15:0] qw,
		logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
		xform_t xf;
		xf.pos.x = px; xf.pos.y = py; xf.pos.z = pz;
		xf.quat.x = qx; xf.quat.y = qy; xf.quat.z = qz; xf.quat.w = qw;
		xf.scl.x = sx; xf.scl.y = sy; xf.scl.z = sz;
		xf.drain_first = 1'b0;
		pending_xforms = {pending_xforms, xf};
	endfunction

	// Idling is allowed except in every fourth block of 128 words and in the tail.
	function automatic logic idle_allowed();
		return (pending_xforms.size() > QUIET_TAIL) && ((accepted_xforms / 128) % 4 != 3);
	endfunction

	// Sender: offers the oldest pending transform, holding it until accepted.
	always @(negedge clk) begin : xform_driver
		logic                        nxt_valid;
		logic [trsam_pkg::IN_DW-1:0] nxt_data;
		xform_t                      xf;
		nxt_valid = s_axis_tvalid;
		nxt_data  = s_axis_tdata;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else begin
			if (xform_taken) begin
				void'(pending_xforms.pop_front());
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_xforms.size() != 0) begin
					xf = pending_xforms[0];
					if (xf.drain_first && expected_mats.size() != 0) begin
						// Wait for every outstanding matrix to come back.
					end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
						src_gap = $urandom_range(1, 19);
					end else begin
						nxt_valid = 1'b1;
						nxt_data = {xf.scl.z, xf.scl.y, xf.scl.x, xf.quat.w, xf.quat.z,
							xf.quat.y, xf.quat.x, xf.pos.z, xf.pos.y, xf.pos.x};
					end
				end
			end
		end
		s_axis_tvalid <= nxt_valid;
		s_axis_tdata  <= nxt_data;
	end

	// Receiver: random stall bursts plus one long hold-off to back up the pipeline.
	always @(negedge clk) begin : matrix_sink
		logic nxt_ready;
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && accepted_xforms >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end else if (snk_gap > 0) begin
				snk_gap--;
			end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
				snk_gap = $urandom_range(1, 19);
			end else begin
				nxt_ready = 1'b1;
			end
		end
		m_axis_tready <= nxt_ready;
	end

	// Check every matrix word against the oldest prediction, then record new
	// transforms; also watch for a stuck pipeline.
	always @(posedge clk) begin : matrix_check
		logic [trsam_pkg::OUT_DW-1:0] exp_word;
		logic                         in_fire;
		logic                         out_fire;
		in_fire  = s_axis_tvalid && s_axis_tready;
		out_fire = m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (out_fire) begin
				if (expected_mats.size() == 0) begin
					$error("matrix word with no transform outstanding");
					mismatch_count++;
				end else begin
					exp_word = expected_mats.pop_front();
					for (int f = 0; f < 12; f++) begin
						if (m_axis_tdata[f*32 +: 32] !== exp_word[f*32 +: 32]) begin
							$error("%s: expected %0d, actual %0d", entry_names[f],
								$signed(exp_word[f*32 +: 32]),
								$signed(m_axis_tdata[f*32 +: 32]));
							mismatch_count++;
						end
					end
				end
			end
			if (in_fire) begin
				expected_mats = {expected_mats, predict_matrix(pending_xforms[0])};
				accepted_xforms++;
			end
			if (in_fire || out_fire) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("trs_to_affine_matrix_unit regression: fail");
				$finish;
			end
		end
		xform_taken <= in_fire;
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		xform_t xf;
		int     kind;
		// Identity rotation with unit scale, plain and with extreme positions, then an all-zero quaternion and scale.
		add_xform(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h100, 16'h100, 16'h100);
		add_xform(32'h7fffffff, 32'h80000000, 32'hffffffff,
			16'h0, 16'h0, 16'h0, 16'h4000, 16'h100, 16'h100, 16'h100);
		add_xform(32'h1, 32'h0, 32'h00010000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		// Non-unit quaternions and extreme scales that drive entries to large magnitudes both ways.
		add_xform(32'h80000000, 32'h7fffffff, 32'h0,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		add_xform(32'h0, 32'h0, 32'h0,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_xform(32'h0, 32'h0, 32'h0,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
		add_xform(32'h0, 32'h0, 32'h0,
			16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h100);
		add_xform(32'h0, 32'h0, 32'h0,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
		// Rounding ties, positive and negative.
		add_xform(32'h0, 32'h0, 32'h0, 16'd64, 16'd64, 16'h0, 16'h0, 16'd64, 16'd64, 16'd64);
		add_xform(32'h0, 32'h0, 32'h0, 16'd64, 16'd64, 16'h0, 16'h0,
			-16'sd64, -16'sd64, -16'sd64);
		add_xform(32'h0, 32'h0, 32'h0, 16'h0, 16'd64, 16'd64, 16'd64, 16'd64, 16'd64, 16'd64);
		// Unit rotations with mixed scales, tiny values and a negated w.
		add_xform(32'h00010000, 32'hffff0000, 32'h12345678,
			16'h0, 16'h0, 16'd11585, 16'd11585, 16'h100, 16'h100, 16'h100);
		add_xform(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h200, 16'hff00, 16'h80);
		add_xform(32'h0, 32'h0, 32'h0, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1);
		add_xform(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h8000, 16'hffff, 16'h1, 16'h7fff);
		add_xform(32'hffffffff, 32'h1, 32'h80000000,
			16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		add_xform(32'h0, 32'h0, 32'h0, 16'd8192, 16'd8192, 16'd8192, 16'd8192,
			16'h100, 16'h100, 16'h100);
		// Random transforms: mostly plausible rotations and scales, some raw
		// noise, some corner values.
		for (int n = 0; n < RANDOM_XFORMS; n++) begin
			kind = $urandom_range(0, 9);
			xf.pos.x = trsam_pkg::pos_e_t'($urandom);
			xf.pos.y = trsam_pkg::pos_e_t'($urandom);
			xf.pos.z = trsam_pkg::pos_e_t'($urandom);
			if (kind < 2) begin
				xf.quat.x = trsam_pkg::quat_e_t'($urandom);
				xf.quat.y = trsam_pkg::quat_e_t'($urandom);
				xf.quat.z = trsam_pkg::quat_e_t'($urandom);
				xf.quat.w = trsam_pkg::quat_e_t'($urandom);
				xf.scl.x = trsam_pkg::scl_e_t'($urandom);
				xf.scl.y = trsam_pkg::scl_e_t'($urandom);
				xf.scl.z = trsam_pkg::scl_e_t'($urandom);
			end else if (kind < 8) begin
				xf.quat.x = trsam_pkg::quat_e_t'(int'($urandom_range(0, 32768)) - 16384);
				xf.quat.y = trsam_pkg::quat_e_t'(int'($urandom_range(0, 32768)) - 16384);
				xf.quat.z = trsam_pkg::quat_e_t'(int'($urandom_range(0, 32768)) - 16384);
				xf.quat.w = trsam_pkg::quat_e_t'(int'($urandom_range(0, 32768)) - 16384);
				xf.scl.x = trsam_pkg::scl_e_t'(int'($urandom_range(0, 2048)) - 1024);
				xf.scl.y = trsam_pkg::scl_e_t'(int'($urandom_range(0, 2048)) - 1024);
				xf.scl.z = trsam_pkg::scl_e_t'(int'($urandom_range(0, 2048)) - 1024);
			end else begin
				xf.quat.x = corner16(); xf.quat.y = corner16();
				xf.quat.z = corner16(); xf.quat.w = corner16();
				xf.scl.x = corner16(); xf.scl.y = corner16(); xf.scl.z = corner16();
				xf.pos.x = {corner16(), corner16()};
				xf.pos.z = {corner16(), corner16()};
			end
			xf.drain_first = (n == DRAIN_AT);
			pending_xforms = {pending_xforms, xf};
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_xforms.size() != 0 || expected_mats.size() != 0) begin
			@(posedge clk);
		end
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("trs_to_affine_matrix_unit regression: pass");
		end else begin
			$display("trs_to_affine_matrix_unit regression: fail");
		end
		$finish;
	end

endmodule
